>>> rtl/core/packet_interval_payload_meter_top_assert.svh
// Assertion macros for the packet interval and payload meter.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef PACKET_INTERVAL_PAYLOAD_METER_TOP_ASSERT_SVH
`define PACKET_INTERVAL_PAYLOAD_METER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Plain property, checked at every clock outside reset
`define PIPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("pipm: assertion failed");
// Same-cycle implication
`define PIPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pipm: implication failed");
// Next-cycle implication
`define PIPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pipm: next-cycle implication failed");
`else
`define PIPM_ASSERT(lbl, prop)
`define PIPM_ASSERT_IMP(lbl, ante, cons)
`define PIPM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/pipm_pkg.sv
// Shared types, constants and helpers of the packet interval and payload meter.
// No dependencies.
package pipm_pkg;

    // Byte total width default
    localparam int unsigned BYTE_COUNT_WIDTH_DEF = 48;

    // Time arithmetic widths
    localparam int unsigned SEC_WIDTH      = 32;
    localparam int unsigned PS_WIDTH       = 40;
    localparam int unsigned SEC_NORM_WIDTH = SEC_WIDTH + 1;
    localparam int unsigned SEC_LO_WIDTH   = 17;
    localparam int unsigned SEC_HI_WIDTH   = SEC_NORM_WIDTH - SEC_LO_WIDTH;
    localparam int unsigned LO_PROD_WIDTH  = SEC_LO_WIDTH + PS_WIDTH;
    localparam int unsigned HI_PROD_WIDTH  = SEC_HI_WIDTH + PS_WIDTH;
    localparam int unsigned ABS_WIDTH      = 72;
    localparam int unsigned DIFF_WIDTH     = ABS_WIDTH + 1;
    localparam int unsigned THR_WIDTH      = 63;

    localparam logic [PS_WIDTH-1:0] PS_PER_SEC = 40'd1000000000000;

    // Header codes
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
    localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [17:0] ETH_HDR_BYTES = 18'd14;
    localparam logic [17:0] UDP_HDR_BYTES = 18'd8;

    typedef enum logic [1:0] {
        LEVEL_FRAME = 2'd0,
        LEVEL_ETH   = 2'd1,
        LEVEL_IP    = 2'd2,
        LEVEL_APP   = 2'd3
    } level_t;

    typedef enum logic {
        KIND_GAP    = 1'b0,
        KIND_WINDOW = 1'b1
    } kind_t;

    typedef enum logic {
        REG_PAYLOAD_LEVEL = 1'b0,
        REG_THRESHOLD     = 1'b1
    } reg_index_t;

    // Clamp a signed picosecond difference to the signed 64-bit range
    function automatic logic signed [63:0] sat_s64(input logic signed [DIFF_WIDTH-1:0] d);
        logic fits;
        fits = (d[DIFF_WIDTH-1:63] == '0) || (d[DIFF_WIDTH-1:63] == '1);
        if (fits) begin
            return d[63:0];
        end else if (d[DIFF_WIDTH-1]) begin
            return {1'b1, 63'd0};
        end else begin
            return {1'b0, {63{1'b1}}};
        end
    endfunction

endpackage

>>> rtl/core/pipm_payload_calc.sv
// Payload size at the selected protocol layer, clamped at zero.
// Depends on pipm_pkg.
module pipm_payload_calc
    import pipm_pkg::*;
(
    input  level_t      level,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [15:0] ip_total_length,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [3:0]  tcp_offset_words,
    input  logic [15:0] udp_length,
    output logic [15:0] payload_bytes
);

    logic        is_ipv4;
    logic [17:0] len_w;
    logic [17:0] iplen_w;
    logic [17:0] ulen_w;
    logic [17:0] ihl_bytes;
    logic [17:0] doff_bytes;
    logic [17:0] size_w;

    // VLAN-tagged frames are parsed as IPv4
    assign is_ipv4    = (ether_type == ETH_TYPE_IPV4) || (ether_type == ETH_TYPE_VLAN);
    assign len_w      = {2'd0, frame_length};
    assign iplen_w    = {2'd0, ip_total_length};
    assign ulen_w     = {2'd0, udp_length};
    assign ihl_bytes  = {12'd0, ip_header_words, 2'd0};
    assign doff_bytes = {12'd0, tcp_offset_words, 2'd0};

    // Two's complement size; bit 17 is the sign
    always_comb begin
        size_w = '0;
        unique case (level)
            LEVEL_FRAME: size_w = len_w;
            LEVEL_ETH:   size_w = len_w - ETH_HDR_BYTES;
            LEVEL_IP: begin
                if (is_ipv4) begin
                    size_w = iplen_w - ihl_bytes;
                end
            end
            LEVEL_APP: begin
                if (is_ipv4 && ip_protocol == IP_PROTO_TCP) begin
                    size_w = iplen_w - doff_bytes - ihl_bytes;
                end else if (is_ipv4 && ip_protocol == IP_PROTO_UDP) begin
                    size_w = ulen_w - UDP_HDR_BYTES;
                end
            end
            default: size_w = '0;
        endcase
    end

    // Negative sizes count as zero
    assign payload_bytes = size_w[17] ? 16'd0 : size_w[15:0];

endmodule

>>> rtl/core/packet_interval_payload_meter_top.sv
// Packet interval and payload meter: top level with time pipeline and window state.
// Depends on pipm_pkg, pipm_payload_calc and packet_interval_payload_meter_top_assert.svh.
//
// Usage:
//   s_* carries one packet header summary and capture stamp per transfer.
//   m_* carries at most one result per packet: m_tuser 0 is an interarrival
//   line, 1 a window report (window closed because the gap exceeded the
//   threshold; the current packet opens the next window).
//   cfg_we/cfg_addr/cfg_wdata write payload_level (0) and the gap threshold (1);
//   write them only while no packet is in flight.
// Throughput: one packet per cycle while the output is not stalled. The only loop is
//   the window state update, one 72-bit subtract and compare against the threshold per packet.
// Pipeline: a result passes normalize, seconds multiply, absolute time sum and
//   window update into the output register, in that order; a stall can hold it.
// Reset (synchronous, aresetn low) empties the pipeline, clears window state
//   and sets payload_level and threshold to zero; no clearing pass follows.
// Stall: with m_tready low the output register holds its result; packets
//   keep entering until the three internal stages fill, then s_tready drops.
`include "packet_interval_payload_meter_top_assert.svh"

module packet_interval_payload_meter_top
    import pipm_pkg::*;
#(
    parameter int unsigned BYTE_COUNT_WIDTH = BYTE_COUNT_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input summary
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_length[15:0], ether_type[31:16], ip_total_length[47:32],
    // ip_header_words[51:48], ip_protocol[59:52], tcp_offset_words[63:60],
    // udp_length[79:64], stamp_seconds[111:80], stamp_picoseconds[151:112]
    input  logic [151:0] s_tdata,
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_seconds[31:0], out_picoseconds[71:32], gap_ps[135:72],
    // window_packets[167:136], window_bytes[215:168], window_span_ps[279:216]
    output logic [279:0] m_tdata,
    // report_kind[0]
    output logic         m_tuser,
    // Configuration
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [62:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    level_t               level_reg;
    logic [THR_WIDTH-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_FRAME;
            thr_reg   <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_PAYLOAD_LEVEL: level_reg <= level_t'(cfg_wdata[1:0]);
                REG_THRESHOLD:     thr_reg   <= cfg_wdata;
                default:           thr_reg   <= thr_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input unpacking
    logic [15:0]          in_frame_length;
    logic [15:0]          in_ether_type;
    logic [15:0]          in_ip_total_length;
    logic [3:0]           in_ip_header_words;
    logic [7:0]           in_ip_protocol;
    logic [3:0]           in_tcp_offset_words;
    logic [15:0]          in_udp_length;
    logic [SEC_WIDTH-1:0] in_sec;
    logic [PS_WIDTH-1:0]  in_ps;
    logic [15:0]          in_payload;

    assign in_frame_length     = s_tdata[15:0];
    assign in_ether_type       = s_tdata[31:16];
    assign in_ip_total_length  = s_tdata[47:32];
    assign in_ip_header_words  = s_tdata[51:48];
    assign in_ip_protocol      = s_tdata[59:52];
    assign in_tcp_offset_words = s_tdata[63:60];
    assign in_udp_length       = s_tdata[79:64];
    assign in_sec              = s_tdata[111:80];
    assign in_ps               = s_tdata[151:112];

    pipm_payload_calc u_payload (
        .level            (level_reg),
        .frame_length     (in_frame_length),
        .ether_type       (in_ether_type),
        .ip_total_length  (in_ip_total_length),
        .ip_header_words  (in_ip_header_words),
        .ip_protocol      (in_ip_protocol),
        .tcp_offset_words (in_tcp_offset_words),
        .udp_length       (in_udp_length),
        .payload_bytes    (in_payload)
    );

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when it is empty or moving on
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic out_free, s3_adv, s3_free, s2_free, s1_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s3_adv   = s3_valid_reg && out_free;
    assign s3_free  = !s3_valid_reg || s3_adv;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: carry a picosecond field of a second or more into the seconds
    logic [SEC_WIDTH-1:0]      s1_sec_reg;
    logic [PS_WIDTH-1:0]       s1_ps_reg;
    logic [SEC_NORM_WIDTH-1:0] s1_sec_norm_reg;
    logic [PS_WIDTH-1:0]       s1_ps_norm_reg;
    logic [15:0]               s1_pay_reg;
    logic                      in_ps_carry;

    assign in_ps_carry = (in_ps >= PS_PER_SEC);

    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_sec_reg      <= in_sec;
            s1_ps_reg       <= in_ps;
            s1_sec_norm_reg <= {1'b0, in_sec} + SEC_NORM_WIDTH'(in_ps_carry);
            s1_ps_norm_reg  <= in_ps_carry ? (in_ps - PS_PER_SEC) : in_ps;
            s1_pay_reg      <= in_payload;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: seconds times 10^12 as two partial products
    logic [SEC_WIDTH-1:0]     s2_sec_reg;
    logic [PS_WIDTH-1:0]      s2_ps_reg;
    logic [PS_WIDTH-1:0]      s2_ps_norm_reg;
    logic [LO_PROD_WIDTH-1:0] s2_lo_prod_reg;
    logic [HI_PROD_WIDTH-1:0] s2_hi_prod_reg;
    logic [15:0]              s2_pay_reg;

    always_ff @(posedge aclk) begin
        if (s2_free) begin
            s2_sec_reg     <= s1_sec_reg;
            s2_ps_reg      <= s1_ps_reg;
            s2_ps_norm_reg <= s1_ps_norm_reg;
            s2_lo_prod_reg <= LO_PROD_WIDTH'(s1_sec_norm_reg[SEC_LO_WIDTH-1:0])
                              * LO_PROD_WIDTH'(PS_PER_SEC);
            s2_hi_prod_reg <= HI_PROD_WIDTH'(s1_sec_norm_reg[SEC_NORM_WIDTH-1:SEC_LO_WIDTH])
                              * HI_PROD_WIDTH'(PS_PER_SEC);
            s2_pay_reg     <= s1_pay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: absolute stamp in picoseconds
    logic [SEC_WIDTH-1:0] s3_sec_reg;
    logic [PS_WIDTH-1:0]  s3_ps_reg;
    logic [ABS_WIDTH-1:0] s3_abs_reg;
    logic [15:0]          s3_pay_reg;

    always_ff @(posedge aclk) begin
        if (s3_free) begin
            s3_sec_reg <= s2_sec_reg;
            s3_ps_reg  <= s2_ps_reg;
            s3_abs_reg <= ABS_WIDTH'({s2_hi_prod_reg, {SEC_LO_WIDTH{1'b0}}})
                          + ABS_WIDTH'(s2_lo_prod_reg) + ABS_WIDTH'(s2_ps_norm_reg);
            s3_pay_reg <= s2_pay_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window state and per-packet decision
    logic                        seen_first_reg, seen_first_next;
    logic [ABS_WIDTH-1:0]        prev_abs_reg, prev_abs_next;
    logic [ABS_WIDTH-1:0]        start_abs_reg, start_abs_next;
    logic [31:0]                 win_pkts_reg, win_pkts_next;
    logic [BYTE_COUNT_WIDTH-1:0] win_bytes_reg, win_bytes_next;

    logic [ABS_WIDTH-1:0]        prev_eff, start_eff;
    logic signed [DIFF_WIDTH-1:0] gap_diff, span_diff;
    logic signed [63:0]          gap_sat;
    logic                        is_report, is_line;
    logic [31:0]                 pkts_base;
    logic [BYTE_COUNT_WIDTH-1:0] bytes_base;
    logic [BYTE_COUNT_WIDTH:0]   byte_sum;
    logic [63:0]                 win_bytes_ext;

    // The first packet stands in for the missing history
    assign prev_eff  = seen_first_reg ? prev_abs_reg  : s3_abs_reg;
    assign start_eff = seen_first_reg ? start_abs_reg : s3_abs_reg;
    assign gap_diff  = $signed({1'b0, s3_abs_reg}) - $signed({1'b0, prev_eff});
    assign span_diff = $signed({1'b0, prev_eff}) - $signed({1'b0, start_eff});
    assign gap_sat   = sat_s64(gap_diff);

    // Positive saturated gap above the threshold closes the window
    assign is_report = !gap_sat[63] && (gap_sat[THR_WIDTH-1:0] > thr_reg);
    assign is_line   = !is_report && (win_pkts_reg != '0);

    assign pkts_base     = is_report ? '0 : win_pkts_reg;
    assign bytes_base    = is_report ? '0 : win_bytes_reg;
    assign byte_sum      = {1'b0, bytes_base} + (BYTE_COUNT_WIDTH + 1)'(s3_pay_reg);
    assign win_bytes_ext = 64'(win_bytes_reg);

    always_comb begin
        seen_first_next = seen_first_reg;
        prev_abs_next   = prev_abs_reg;
        start_abs_next  = start_abs_reg;
        win_pkts_next   = win_pkts_reg;
        win_bytes_next  = win_bytes_reg;
        if (s3_adv) begin
            seen_first_next = 1'b1;
            prev_abs_next   = s3_abs_reg;
            start_abs_next  = (is_report || !seen_first_reg) ? s3_abs_reg : start_abs_reg;
            win_pkts_next   = (pkts_base == '1) ? pkts_base : pkts_base + 32'd1;
            win_bytes_next  = byte_sum[BYTE_COUNT_WIDTH] ? '1 : byte_sum[BYTE_COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_first_reg <= 1'b0;
            prev_abs_reg   <= '0;
            start_abs_reg  <= '0;
            win_pkts_reg   <= '0;
            win_bytes_reg  <= '0;
        end else begin
            seen_first_reg <= seen_first_next;
            prev_abs_reg   <= prev_abs_next;
            start_abs_reg  <= start_abs_next;
            win_pkts_reg   <= win_pkts_next;
            win_bytes_reg  <= win_bytes_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    kind_t                m_kind_reg;
    logic [SEC_WIDTH-1:0] m_sec_reg;
    logic [PS_WIDTH-1:0]  m_ps_reg;
    logic [63:0]          m_gap_reg;
    logic [31:0]          m_wpkts_reg;
    logic [47:0]          m_wbytes_reg;
    logic [63:0]          m_span_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s3_adv) begin
            m_valid_reg <= is_report || is_line;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            m_kind_reg   <= is_report ? KIND_WINDOW : KIND_GAP;
            m_sec_reg    <= s3_sec_reg;
            m_ps_reg     <= s3_ps_reg;
            m_gap_reg    <= gap_sat;
            m_wpkts_reg  <= is_report ? win_pkts_reg : '0;
            m_wbytes_reg <= is_report ? win_bytes_ext[47:0] : '0;
            m_span_reg   <= is_report ? sat_s64(span_diff) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_span_reg, m_wbytes_reg, m_wpkts_reg, m_gap_reg, m_ps_reg, m_sec_reg};

    // ------------------------------------------------------------------
    // Checks
    `PIPM_ASSERT_IMP(a_report_needs_history, s3_adv && is_report, seen_first_reg)
    `PIPM_ASSERT_NXT(a_count_nonzero_after_packet, s3_adv, win_pkts_reg != '0)
    `PIPM_ASSERT_IMP(a_report_gap_positive, m_valid_reg && (m_kind_reg == KIND_WINDOW),
                     !m_gap_reg[63] && (m_gap_reg != '0))
    `PIPM_ASSERT_IMP(a_result_from_stage3, $rose(m_valid_reg), $past(s3_adv))

endmodule
